// File: hw/rtl/grc_pkg.sv
// ----------------------------------------------------------------------------
// grc_pkg
// Shared types, codes and the CRC-8 step for the gap-framed receiver.
// ----------------------------------------------------------------------------
package grc_pkg;

    // Frame limit ceiling used when no other value is handed down
    localparam int MAX_FRAME_DEF = 256;

    // Field widths
    localparam int LEN_W  = 9;
    localparam int GAP_W  = 8;
    localparam int BYTE_W = 8;
    localparam int IDX_W  = 8;
    localparam int STAT_W = 2;
    localparam int REG_W  = 9;
    localparam int ADDR_W = 1;

    // Register reset values
    localparam logic [LEN_W-1:0] MAX_LENGTH_RST = 9'd64;
    localparam logic [GAP_W-1:0] GAP_TICKS_RST  = 8'd2;

    // Shortest frame that carries a check byte
    localparam logic [LEN_W-1:0] MIN_FRAME_BYTES = 9'd4;

    // Reflected CRC-8 polynomial
    localparam logic [7:0] CRC_POLY = 8'h8C;

    // Register indexes
    localparam logic [ADDR_W-1:0] REG_MAX_LENGTH = 1'b0;
    localparam logic [ADDR_W-1:0] REG_GAP_TICKS  = 1'b1;

    // Input operation codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Frame end status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] STAT_SHORT    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_CRC_ERR  = 2'd3;

    // Classified item handed from the front to the back
    typedef struct packed {
        logic              op;
        logic [BYTE_W-1:0] data;
    } cmd_t;

    // One result item
    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] data_byte;
        logic [IDX_W-1:0]  byte_index;
        logic [STAT_W-1:0] status;
        logic [LEN_W-1:0]  frame_length;
    } res_t;

    // One byte through the reflected CRC-8, LSB first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc_in,
                                             input logic [7:0] data_in);
        logic [7:0] crc;
        logic [7:0] d;
        crc = crc_in;
        d   = data_in;
        for (int b = 0; b < 8; b++) begin
            if ((crc[0] ^ d[0]) == 1'b1)
            begin
                crc = (crc >> 1) ^ CRC_POLY;
            end
            else
            begin
                crc = crc >> 1;
            end
            d = d >> 1;
        end
        return crc;
    endfunction

endpackage

// File: hw/rtl/grc_fifo.sv
// ----------------------------------------------------------------------------
// grc_fifo
// Small register queue with same-cycle push and pop.
// ----------------------------------------------------------------------------
module grc_fifo #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count beyond depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue count missed a push");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("queue count missed a pop");

endmodule

// File: hw/rtl/grc_front.sv
// ----------------------------------------------------------------------------
// grc_front
// Input side: classify each item as byte or tick and queue it for the back.
// ----------------------------------------------------------------------------
module grc_front
    import grc_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              op,
    input  logic [BYTE_W-1:0] rx_byte,
    output logic              full,
    output logic              cmd_valid,
    output cmd_t              cmd,
    input  logic              cmd_pop
);

    cmd_t cmd_in;
    logic cmd_empty;

    // Drop the byte field of a tick so that stale data never travels on
    always_comb
    begin
        cmd_in.op   = op;
        cmd_in.data = (op == OP_BYTE) ? rx_byte : '0;
    end

    grc_fifo #(
        .DEPTH (DEPTH),
        .WIDTH ($bits(cmd_t))
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cmd_in),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd),
        .empty (cmd_empty)
    );

    assign cmd_valid = !cmd_empty;

endmodule

// File: hw/rtl/grc_back.sv
// ----------------------------------------------------------------------------
// grc_back
// Frame engine: track frame state, run the CRC, emit a result per byte and frame close.
// ----------------------------------------------------------------------------
module grc_back
    import grc_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [LEN_W-1:0] max_length,
    input  logic [GAP_W-1:0] gap_ticks,
    input  logic             cmd_valid,
    input  cmd_t             cmd,
    output logic             cmd_pop,
    output logic             res_valid,
    output res_t             res,
    input  logic             res_full
);

    localparam int LIM_W = LEN_W + 8;
    localparam logic [LIM_W-1:0] MAX_FRAME_L = LIM_W'(MAX_FRAME);

    logic              in_frame_reg, in_frame_next;
    logic [LEN_W-1:0]  byte_count_reg, byte_count_next;
    logic [GAP_W-1:0]  idle_count_reg, idle_count_next;
    logic [7:0]        crc_reg, crc_next;
    logic [BYTE_W-1:0] held_reg, held_next;

    logic [LEN_W-1:0]  limit;
    logic [LEN_W-1:0]  pos;
    logic [LEN_W-1:0]  count_inc;
    logic [7:0]        crc_base;
    logic [7:0]        crc_step;
    logic [GAP_W:0]    idle_inc;
    logic [STAT_W-1:0] close_status;

    // Cap the configured length at the frame ceiling
    assign limit = ({8'd0, max_length} > MAX_FRAME_L) ? MAX_FRAME_L[LEN_W-1:0]
                                                        : max_length;

    assign cmd_pop   = cmd_valid && !res_full;
    assign pos       = in_frame_reg ? byte_count_reg : '0;
    assign crc_base  = in_frame_reg ? crc_reg : 8'd0;
    assign crc_step  = crc8_step(crc_base, held_reg);
    assign count_inc = pos + LEN_W'(1);
    assign idle_inc  = {1'b0, idle_count_reg} + (GAP_W + 1)'(1);

    always_comb
    begin
        priority if (byte_count_reg < MIN_FRAME_BYTES)
        begin
            close_status = STAT_SHORT;
        end
        else if (crc_reg != held_reg)
        begin
            close_status = STAT_CRC_ERR;
        end
        else
        begin
            close_status = STAT_OK;
        end
    end

    always_comb
    begin
        in_frame_next   = in_frame_reg;
        byte_count_next = byte_count_reg;
        idle_count_next = idle_count_reg;
        crc_next        = crc_reg;
        held_next       = held_reg;
        res_valid       = 1'b0;
        res             = '0;
        if (cmd_pop)
        begin
            if (cmd.op == OP_BYTE)
            begin
                if (count_inc >= limit)
                begin
                    res_valid        = 1'b1;
                    res.kind         = KIND_STATUS;
                    res.status       = STAT_OVERFLOW;
                    res.frame_length = count_inc;
                    in_frame_next    = 1'b0;
                    byte_count_next  = '0;
                    idle_count_next  = '0;
                    crc_next         = '0;
                    held_next        = '0;
                end
                else
                begin
                    res_valid       = 1'b1;
                    res.kind        = KIND_DATA;
                    res.data_byte   = cmd.data;
                    res.byte_index  = pos[IDX_W-1:0];
                    in_frame_next   = 1'b1;
                    byte_count_next = count_inc;
                    idle_count_next = '0;
                    held_next       = cmd.data;
                    crc_next        = (pos != '0) ? crc_step : crc_base;
                end
            end
            else if (in_frame_reg)
            begin
                if (idle_inc <= {1'b0, gap_ticks})
                begin
                    idle_count_next = idle_inc[GAP_W-1:0];
                end
                else
                begin
                    res_valid        = 1'b1;
                    res.kind         = KIND_STATUS;
                    res.status       = close_status;
                    res.frame_length = byte_count_reg;
                    in_frame_next    = 1'b0;
                    byte_count_next  = '0;
                    idle_count_next  = '0;
                    crc_next         = '0;
                    held_next        = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg   <= 1'b0;
            byte_count_reg <= '0;
            idle_count_reg <= '0;
            crc_reg        <= '0;
            held_reg       <= '0;
        end
        else
        begin
            in_frame_reg   <= in_frame_next;
            byte_count_reg <= byte_count_next;
            idle_count_reg <= idle_count_next;
            crc_reg        <= crc_next;
            held_reg       <= held_next;
        end
    end

    a_close_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind == KIND_STATUS) |=> !in_frame_reg)
        else $error("frame still open after status item");

    a_idle_is_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !in_frame_reg |-> (byte_count_reg == '0 && idle_count_reg == '0))
        else $error("idle state left counts behind");

    a_no_pop_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (cmd_valid && !res_full))
        else $error("item taken while result queue full");

endmodule

// File: hw/rtl/gap_framed_crc8_receiver.sv
// ----------------------------------------------------------------------------
// gap_framed_crc8_receiver
// Deframes a gap-separated serial byte stream and checks a CRC-8 per frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive op/rx_byte and raise push; the item is taken at a
//   clock edge with push high and full low. op = 0 carries a received byte,
//   op = 1 carries one millisecond tick.
//   Result channel: while empty is low the oldest result sits on kind,
//   data_byte, byte_index, status and frame_length; raise pop to take it.
//   Each byte yields a data item with its frame position; a frame closes on
//   a gap longer than gap_ticks ticks (status ok, too short or crc mismatch)
//   or on reaching max_length bytes (overflow status in place of the byte).
//   Configuration: cfg_we with cfg_idx/cfg_data writes max_length (0) or
//   gap_ticks (1); write only while no item is in flight.
//   A taken item is registered in the input queue, passes the frame engine
//   and is registered again in the result queue once that queue has room.
//   Throughput: one item per cycle while the result queue has room, the
//   CRC-8 step being one byte of XOR logic per cycle.
//   A two-entry queue sits on each side of the engine, so input stays open
//   while results wait; when the receiver stops popping, the result queue
//   fills, the engine holds, and full rises once the input queue fills too.
//   Reset empties both queues, closes any open frame and loads the register
//   defaults (max_length 64, gap_ticks 2).
// ----------------------------------------------------------------------------
module gap_framed_crc8_receiver
    import grc_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF,
    parameter int CMD_DEPTH = 2,
    parameter int RES_DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    // configuration write port
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_idx,
    input  logic [REG_W-1:0]  cfg_data,
    // input queue side
    input  logic              push,
    output logic              full,
    input  logic              op,
    input  logic [BYTE_W-1:0] rx_byte,
    // result queue side
    output logic              empty,
    input  logic              pop,
    output logic              kind,
    output logic [BYTE_W-1:0] data_byte,
    output logic [IDX_W-1:0]  byte_index,
    output logic [STAT_W-1:0] status,
    output logic [LEN_W-1:0]  frame_length
);

    logic [LEN_W-1:0] max_length_reg;
    logic [GAP_W-1:0] gap_ticks_reg;

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;
    logic res_valid;
    res_t res;
    logic res_full;
    res_t res_head;

    // Configuration registers: take a write whenever enabled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= MAX_LENGTH_RST;
            gap_ticks_reg  <= GAP_TICKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_MAX_LENGTH: max_length_reg <= cfg_data;
                REG_GAP_TICKS:  gap_ticks_reg  <= cfg_data[GAP_W-1:0];
                default:        ;
            endcase
        end
    end

    // Front: accept and classify items
    grc_front #(
        .DEPTH (CMD_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .op        (op),
        .rx_byte   (rx_byte),
        .full      (full),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // Back: advance the frame state, one item per cycle while the result queue has room
    grc_back #(
        .MAX_FRAME (MAX_FRAME)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .max_length (max_length_reg),
        .gap_ticks  (gap_ticks_reg),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop),
        .res_valid  (res_valid),
        .res        (res),
        .res_full   (res_full)
    );

    // Hold results until the receiver pops them
    grc_fifo #(
        .DEPTH (RES_DEPTH),
        .WIDTH ($bits(res_t))
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_valid),
        .wdata (res),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_head),
        .empty (empty)
    );

    assign kind         = res_head.kind;
    assign data_byte    = res_head.data_byte;
    assign byte_index   = res_head.byte_index;
    assign status       = res_head.status;
    assign frame_length = res_head.frame_length;

endmodule
